// ===== design/rlstk_pkg.sv =====
package rlstk_pkg;

	// Field widths of the command and result transactions, the APB address width and the default run depth.
	localparam int RLSTK_DATA_W     = 32;
	localparam int RLSTK_CMD_W      = 2;
	localparam int RLSTK_STATUS_W   = 2;
	localparam int RLSTK_S_TDATA_W  = 72;
	localparam int RLSTK_M_TDATA_W  = 40;
	localparam int RLSTK_PADDR_W    = 3;
	localparam int RLSTK_RUN_DEPTH  = 64;

	// Command codes.
	localparam logic [RLSTK_CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [RLSTK_CMD_W-1:0] CMD_POP  = 2'd1;
	localparam logic [RLSTK_CMD_W-1:0] CMD_TOP  = 2'd2;
	localparam logic [RLSTK_CMD_W-1:0] CMD_SIZE = 2'd3;

	// Sticky status codes.
	localparam logic [RLSTK_STATUS_W-1:0] STAT_SAFE  = 2'd0;
	localparam logic [RLSTK_STATUS_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [RLSTK_STATUS_W-1:0] STAT_EMPTY = 2'd2;

	// Register index of the capacity register.
	localparam logic REG_CAPACITY = 1'b0;

	// One stored run: its value and how many copies it holds.
	typedef struct packed {
		logic [RLSTK_DATA_W-1:0] value;
		logic [RLSTK_DATA_W-1:0] count;
	} run_t;

	localparam int RLSTK_RUN_W = $bits(run_t);

endpackage

// ===== design/run_length_stack.sv =====
// Run-length stack: a stack whose elements are held as runs of equal values.
// Commands arrive as transactions on the s_ channel (push, pop, top, size);
// every command gives exactly one result transaction on the m_ channel with
// the answer (m_tuser high when m_tdata holds a top or size answer) and the
// sticky status. Capacity is to be written over the APB port only while the
// block idles; the block itself does not enforce this. Runs live in a single
// synchronous RAM of RUN_DEPTH entries; run count and total size are kept in
// registers. Size, top on an empty stack, a push onto an empty stack,
// commands with a zero amount and commands that fail a check or are ignored
// go from the execute state straight to the output state. Top and a push onto
// a non-empty stack first read the top run from the RAM, also when that push
// is refused because the run store is full. A pop walks the runs, reading one
// run per cycle through the RAM read port. One command is processed at a
// time; the next command is accepted in the cycle after the result is loaded
// into the output register, so no new command is taken while one is in
// flight. If the receiver stalls, the finished result waits until the output
// register is free, and input is held off.
// Reset empties the stack, clears the status to safe and sets the capacity
// to its maximum; the RAM is not cleared, since only written runs are read.
module run_length_stack
	import rlstk_pkg::*;
#(
	parameter int RUN_DEPTH = RLSTK_RUN_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// s_tdata: cmd [1:0], amount [33:2], value [65:34], zero padding above
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [RLSTK_S_TDATA_W-1:0] s_tdata,
	// m_tdata: data [31:0], status [33:32], zero padding above
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [RLSTK_M_TDATA_W-1:0] m_tdata,
	// m_tuser: data_valid [0]
	output logic                       m_tuser,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [RLSTK_PADDR_W-1:0]   paddr,
	input  logic [RLSTK_DATA_W-1:0]    pwdata,
	output logic [RLSTK_DATA_W-1:0]    prdata,
	output logic                       pready
);

	localparam int ADDR_W  = $clog2(RUN_DEPTH);
	localparam int DEPTH_W = $clog2(RUN_DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_PUSH = 3'd2;
	localparam logic [2:0] ST_TOP  = 3'd3;
	localparam logic [2:0] ST_POP  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]                state_q, state_d;
	logic [DEPTH_W-1:0]        depth_q, depth_d;
	logic [RLSTK_DATA_W-1:0]   total_q, total_d;
	logic [RLSTK_STATUS_W-1:0] err_q, err_d;
	logic [RLSTK_DATA_W-1:0]   capacity_q;
	logic [RLSTK_DATA_W-1:0]   left_q, left_d;
	logic [RLSTK_DATA_W-1:0]   res_data_q, res_data_d;
	logic                      res_valid_q, res_valid_d;

	logic [RLSTK_CMD_W-1:0]    cmd_q;
	logic [RLSTK_DATA_W-1:0]   amount_q;
	logic [RLSTK_DATA_W-1:0]   value_q;

	logic                      m_tvalid_q;
	logic [RLSTK_M_TDATA_W-1:0] m_tdata_q;
	logic                      m_tuser_q;

	logic                      ram_we, ram_re;
	logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
	run_t                      ram_wdata, ram_rdata;

	logic [ADDR_W-1:0]         top_addr, below_addr;
	logic [RLSTK_DATA_W:0]     push_sum;
	logic                      over_cap;
	logic                      accept, out_free, cfg_write;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	// Addresses of the top run and the run beneath it.
	assign top_addr   = ADDR_W'(depth_q - DEPTH_W'(1));
	assign below_addr = ADDR_W'(depth_q - DEPTH_W'(2));

	// Capacity check on the unwrapped sum.
	assign push_sum = {1'b0, total_q} + {1'b0, amount_q};
	assign over_cap = push_sum > {1'b0, capacity_q};

	// APB register access.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == REG_CAPACITY) ? capacity_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '1;
		end else if (cfg_write && paddr[2] == REG_CAPACITY) begin
			capacity_q <= pwdata;
		end
	end

	// Sequencer: decide the command, read the top run, modify and write back.
	always_comb begin
		state_d     = state_q;
		depth_d     = depth_q;
		total_d     = total_q;
		err_d       = err_q;
		left_d      = left_q;
		res_data_d  = res_data_q;
		res_valid_d = res_valid_q;
		ram_we      = 1'b0;
		ram_waddr   = top_addr;
		ram_wdata   = '0;
		ram_re      = 1'b0;
		ram_raddr   = top_addr;
		unique case (state_q)
			ST_IDLE: begin
				res_data_d  = '0;
				res_valid_d = 1'b0;
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_OUT;
				if (err_q == STAT_SAFE) begin
					unique case (cmd_q)
						CMD_PUSH: begin
							if (over_cap) begin
								err_d = STAT_FULL;
							end else if (amount_q != '0) begin
								if (depth_q == '0) begin
									ram_we    = 1'b1;
									ram_waddr = '0;
									ram_wdata = '{value: value_q, count: amount_q};
									depth_d   = DEPTH_W'(1);
									total_d   = push_sum[RLSTK_DATA_W-1:0];
								end else begin
									ram_re  = 1'b1;
									state_d = ST_PUSH;
								end
							end
						end
						CMD_POP: begin
							if (amount_q > total_q) begin
								err_d = STAT_EMPTY;
							end else if (amount_q != '0) begin
								total_d = total_q - amount_q;
								left_d  = amount_q;
								ram_re  = 1'b1;
								state_d = ST_POP;
							end
						end
						CMD_TOP: begin
							if (depth_q == '0) begin
								err_d = STAT_EMPTY;
							end else begin
								ram_re  = 1'b1;
								state_d = ST_TOP;
							end
						end
						CMD_SIZE: begin
							res_data_d  = total_q;
							res_valid_d = 1'b1;
						end
						default: begin
							state_d = ST_OUT;
						end
					endcase
				end
			end
			ST_PUSH: begin
				state_d = ST_OUT;
				if (ram_rdata.value == value_q) begin
					// Same value on top: grow that run.
					ram_we    = 1'b1;
					ram_waddr = top_addr;
					ram_wdata = '{value: value_q, count: ram_rdata.count + amount_q};
					total_d   = push_sum[RLSTK_DATA_W-1:0];
				end else if (depth_q == DEPTH_W'(RUN_DEPTH)) begin
					err_d = STAT_FULL;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = ADDR_W'(depth_q);
					ram_wdata = '{value: value_q, count: amount_q};
					depth_d   = depth_q + DEPTH_W'(1);
					total_d   = push_sum[RLSTK_DATA_W-1:0];
				end
			end
			ST_TOP: begin
				res_data_d  = ram_rdata.value;
				res_valid_d = 1'b1;
				state_d     = ST_OUT;
			end
			ST_POP: begin
				if (left_q >= ram_rdata.count) begin
					// Whole run consumed; carry on with the run beneath.
					left_d  = left_q - ram_rdata.count;
					depth_d = depth_q - DEPTH_W'(1);
					if (left_q == ram_rdata.count) begin
						state_d = ST_OUT;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = below_addr;
					end
				end else begin
					// Trim the last run reached.
					ram_we    = 1'b1;
					ram_waddr = top_addr;
					ram_wdata = '{value: ram_rdata.value, count: ram_rdata.count - left_q};
					left_d    = '0;
					state_d   = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and stack bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			depth_q     <= '0;
			total_q     <= '0;
			err_q       <= STAT_SAFE;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			total_q <= total_d;
			err_q   <= err_d;
			if (state_q == ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers: the command in flight and the result being built.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_tdata[1:0];
			amount_q <= s_tdata[33:2];
			value_q  <= s_tdata[65:34];
		end
		left_q      <= left_d;
		res_data_q  <= res_data_d;
		res_valid_q <= res_valid_d;
		if (state_q == ST_OUT && out_free) begin
			m_tdata_q <= {{(RLSTK_M_TDATA_W - RLSTK_DATA_W - RLSTK_STATUS_W){1'b0}},
				err_q, res_data_q};
			m_tuser_q <= res_valid_q;
		end
	end

	rlstk_ram #(
		.WIDTH (RLSTK_RUN_W),
		.DEPTH (RUN_DEPTH)
	) u_runs (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== design/rlstk_ram.sv =====
module rlstk_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, single registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/rlstk_checker.sv =====
module rlstk_checker
	import rlstk_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [RLSTK_M_TDATA_W-1:0] m_tdata,
	input logic                       m_tuser
);

	logic                      err_seen_q;
	logic [RLSTK_STATUS_W-1:0] err_val_q;

	// Remember the first error status delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
			err_val_q  <= STAT_SAFE;
		end else if (m_tvalid && m_tready && !err_seen_q &&
			m_tdata[33:32] != STAT_SAFE) begin
			err_seen_q <= 1'b1;
			err_val_q  <= m_tdata[33:32];
		end
	end

	// A stalled result holds its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Once an error has been reported, the status never changes again.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && err_seen_q |-> m_tdata[33:32] == err_val_q)
		else $error("sticky status changed");

	// A result carrying an error status never carries an answer.
	a_no_answer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] != STAT_SAFE |-> !m_tuser)
		else $error("answer given under an error status");

	// Data is zero whenever it holds no answer.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:0] == '0)
		else $error("data not zero without an answer");

endmodule

bind run_length_stack rlstk_checker u_rlstk_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
